// ----- sv/media_manifest_sniffer_defines.svh -----
// Assertion helpers shared by the RTL of the manifest sniffer.
`ifndef MEDIA_MANIFEST_SNIFFER_DEFINES_SVH
`define MEDIA_MANIFEST_SNIFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sniffer check failed");

// The consequent must hold in the cycle after the antecedent.
`define MMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sniffer check failed");

`endif

// ----- sv/mms_pkg.sv -----
`timescale 1ns / 1ps

package mms_pkg;

   // Depth of the folded-byte history; the longest pattern needs one less than its length.
   localparam int WINDOW_DEPTH = 20;

   localparam int POS_W = 8;
   localparam logic [POS_W-1:0] POS_MAX = 8'd255;
   localparam logic [7:0] EARLY_LIMIT_RESET = 8'd10;

   localparam logic [7:0] MARK_FIRST = 8'hFF;
   localparam logic [7:0] MARK_SECOND = 8'hFE;

   // Patterns are right aligned: the final character sits in bits [7:0].
   localparam int PAT_MAX_LEN = 21;
   localparam int PAT_W = PAT_MAX_LEN * 8;

   localparam int PAT_ASX_LEN = 4;
   localparam int PAT_M3U_LEN = 7;
   localparam int PAT_SMOOTH_LEN = 21;
   localparam int PAT_WMS_LEN = 12;

   localparam logic [PAT_W-1:0] PAT_ASX = PAT_W'("<asx");
   localparam logic [PAT_W-1:0] PAT_M3U = PAT_W'("#extm3u");
   localparam logic [PAT_W-1:0] PAT_SMOOTH = PAT_W'("<smoothstreamingmedia");
   localparam logic [PAT_W-1:0] PAT_WMS = PAT_W'("mswmext=.asf");

   // Bit positions in the sticky found vector.
   localparam int FOUND_ASX = 0;
   localparam int FOUND_M3U = 1;
   localparam int FOUND_SMOOTH = 2;
   localparam int FOUND_WMS = 3;

   typedef enum logic [2:0] {
      FMT_ASX = 3'd0,
      FMT_M3U = 3'd1,
      FMT_SMOOTH = 3'd2,
      FMT_WMS = 3'd3,
      FMT_PROGRESSIVE = 3'd4,
      FMT_WIDE = 3'd5
   } format_class_type;

endpackage

// ----- sv/media_manifest_sniffer.sv -----
`timescale 1ns / 1ps
// The class appears on the result channel in the cycle after the final byte is taken.
// The sniffer takes one byte per cycle while no result is stalled; the window compare
// and the class choice are combinational, between the byte handshake and result register.
// A result waiting on a stalled result channel holds off the byte stream until it is taken.
// Reset (synchronous, active high) clears the window, position and flags, empties the
// result register and loads early_limit with 10; no clearing pass is needed.

`include "media_manifest_sniffer_defines.svh"

module media_manifest_sniffer (
   input  logic       clock,
   input  logic       reset,
   // Content byte stream.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_value
   input  logic       req_tlast,   // last_byte
   // Classification result, one transaction per content.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] format_class, [7:3] zero
   // early_limit register write.
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   // The register is a plain flop and can take a write in any cycle.
   logic [7:0] early_limit_ff;

   // Per-content state.
   logic [7:0]              window_ff [mms_pkg::WINDOW_DEPTH];
   logic [7:0]              window_in [mms_pkg::WINDOW_DEPTH];
   logic [mms_pkg::POS_W-1:0] position_ff, position_in;
   logic [3:0]              found_ff, found_in;
   logic                    text_ended_ff, text_ended_in;
   logic                    mark_ff, mark_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   mms_pkg::format_class_type rsp_class_ff, rsp_class_in;

   logic       req_fire;
   logic [7:0] raw_byte;
   logic [7:0] folded;
   logic       in_text;
   logic       hit_asx, hit_m3u, hit_smooth, hit_wms;
   logic [3:0] found_now;
   logic       mark_now;

   // True when the pattern ends at cur with its earlier characters in the window.
   function automatic logic tail_match(input logic [7:0] win [mms_pkg::WINDOW_DEPTH],
                                       input logic [7:0] cur,
                                       input logic [mms_pkg::PAT_W-1:0] pat,
                                       input int len);
      logic ok;
      ok = (cur == pat[7:0]);
      for (int i = 0; i < mms_pkg::WINDOW_DEPTH; i++) begin
         if ((i + 1 < len) && (win[i] != pat[(i+1)*8 +: 8])) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // A head pattern counts only if its first byte lies below the early limit.
   function automatic logic near_head(input logic [mms_pkg::POS_W-1:0] pos,
                                      input logic [7:0] limit,
                                      input int len);
      logic [mms_pkg::POS_W:0] end_count;
      logic [mms_pkg::POS_W:0] pat_len;
      end_count = {1'b0, pos} + 9'd1;
      pat_len = 9'(len);
      return (pos != mms_pkg::POS_MAX) && (end_count >= pat_len) &&
             ((end_count - pat_len) < {1'b0, limit});
   endfunction

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'd0, rsp_class_ff};

   assign raw_byte = req_tdata;

   always_comb begin
      folded = raw_byte;
      if (raw_byte inside {[8'h41:8'h5A]}) begin
         folded = raw_byte + 8'd32;
      end
   end

   // A zero byte ends the text; it and everything after it skip matching.
   assign text_ended_in = text_ended_ff || (raw_byte == 8'd0);
   assign in_text = !text_ended_in;

   assign hit_asx = tail_match(window_ff, folded, mms_pkg::PAT_ASX, mms_pkg::PAT_ASX_LEN) &&
                    near_head(position_ff, early_limit_ff, mms_pkg::PAT_ASX_LEN);
   assign hit_m3u = tail_match(window_ff, folded, mms_pkg::PAT_M3U, mms_pkg::PAT_M3U_LEN) &&
                    near_head(position_ff, early_limit_ff, mms_pkg::PAT_M3U_LEN);
   assign hit_smooth = tail_match(window_ff, folded, mms_pkg::PAT_SMOOTH,
                                  mms_pkg::PAT_SMOOTH_LEN);
   assign hit_wms = tail_match(window_ff, folded, mms_pkg::PAT_WMS, mms_pkg::PAT_WMS_LEN);

   always_comb begin
      found_now = found_ff;
      if (in_text) begin
         found_now[mms_pkg::FOUND_ASX] = found_ff[mms_pkg::FOUND_ASX] | hit_asx;
         found_now[mms_pkg::FOUND_M3U] = found_ff[mms_pkg::FOUND_M3U] | hit_m3u;
         found_now[mms_pkg::FOUND_SMOOTH] = found_ff[mms_pkg::FOUND_SMOOTH] | hit_smooth;
         found_now[mms_pkg::FOUND_WMS] = found_ff[mms_pkg::FOUND_WMS] | hit_wms;
      end
   end

   // Byte-order mark: first byte FF arms it, a second byte other than FE drops it.
   always_comb begin
      mark_now = mark_ff;
      if (position_ff == '0) begin
         mark_now = (raw_byte == mms_pkg::MARK_FIRST);
      end else if ((position_ff == 8'd1) && (raw_byte != mms_pkg::MARK_SECOND)) begin
         mark_now = 1'b0;
      end
   end

   // Class of the content if this byte is the final one.
   always_comb begin
      if (mark_now && (position_ff != '0)) begin
         rsp_class_in = mms_pkg::FMT_WIDE;
      end else if (found_now[mms_pkg::FOUND_ASX]) begin
         rsp_class_in = mms_pkg::FMT_ASX;
      end else if (found_now[mms_pkg::FOUND_M3U]) begin
         rsp_class_in = mms_pkg::FMT_M3U;
      end else if (found_now[mms_pkg::FOUND_SMOOTH]) begin
         rsp_class_in = mms_pkg::FMT_SMOOTH;
      end else if (found_now[mms_pkg::FOUND_WMS]) begin
         rsp_class_in = mms_pkg::FMT_WMS;
      end else begin
         rsp_class_in = mms_pkg::FMT_PROGRESSIVE;
      end
   end

   // Next per-content state. The final byte returns everything to its reset values.
   always_comb begin
      window_in = window_ff;
      position_in = position_ff;
      found_in = found_ff;
      mark_in = mark_ff;
      if (req_fire) begin
         if (req_tlast) begin
            for (int i = 0; i < mms_pkg::WINDOW_DEPTH; i++) begin
               window_in[i] = 8'd0;
            end
            position_in = '0;
            found_in = '0;
            mark_in = 1'b0;
         end else begin
            if (in_text) begin
               for (int i = mms_pkg::WINDOW_DEPTH - 1; i > 0; i--) begin
                  window_in[i] = window_ff[i-1];
               end
               window_in[0] = folded;
            end
            if (position_ff != mms_pkg::POS_MAX) begin
               position_in = position_ff + 8'd1;
            end
            found_in = found_now;
            mark_in = mark_now;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire && req_tlast) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         early_limit_ff <= mms_pkg::EARLY_LIMIT_RESET;
         for (int i = 0; i < mms_pkg::WINDOW_DEPTH; i++) begin
            window_ff[i] <= 8'd0;
         end
         position_ff <= '0;
         found_ff <= '0;
         text_ended_ff <= 1'b0;
         mark_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            early_limit_ff <= csr_data;
         end
         window_ff <= window_in;
         position_ff <= position_in;
         found_ff <= found_in;
         mark_ff <= mark_in;
         if (req_fire) begin
            text_ended_ff <= req_tlast ? 1'b0 : text_ended_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_tlast) begin
         rsp_class_ff <= rsp_class_in;
      end
   end

   // The final byte leaves a pending result and a cleared content state.
   `MMS_ASSERT_NEXT(a_last_clears, clock, reset, req_fire && req_tlast, rsp_valid_ff && (position_ff == '0) && (found_ff == '0) && !text_ended_ff && !mark_ff)
   // A stalled result must hold off the byte stream.
   `MMS_ASSERT_SAME(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready)
   // The position advances by one per non-final byte until it saturates.
   `MMS_ASSERT_NEXT(a_pos_step, clock, reset, req_fire && !req_tlast && (position_ff != mms_pkg::POS_MAX), position_ff == $past(position_ff) + 8'd1)
   // Without a byte taken, the per-content state does not move.
   `MMS_ASSERT_NEXT(a_idle_hold, clock, reset, !req_fire, $stable(position_ff) && $stable(found_ff))

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } stream_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] byte_value
   logic       req_tlast = 1'b0;    // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [2:0] format_class, [7:3] zero
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'h00;

   // Bytes waiting to be offered, and the classes the sniffer owes us.
   stream_byte_type           pending_bytes[$];
   mms_pkg::format_class_type expected_classes[$];
   // Content under construction before it is handed to the byte driver.
   logic [7:0]                draft[$];

   // Our own copy of the sniffer state and its one register.
   logic [7:0] early_limit_model = mms_pkg::EARLY_LIMIT_RESET;
   logic [7:0] sniff_window [mms_pkg::WINDOW_DEPTH];
   logic [7:0] sniff_pos;
   logic [3:0] sniff_found;
   logic       sniff_ended;
   logic       sniff_mark;

   int errors = 0;
   int results_seen = 0;
   int send_gap = 0;
   int recv_wait = 0;
   bit send_quiet = 1'b0;
   bit recv_quiet = 1'b0;

   media_manifest_sniffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Patterns are indexed by their bit in the found vector.
   function automatic logic [mms_pkg::PAT_W-1:0] pattern_text(input int idx);
      case (idx)
         mms_pkg::FOUND_ASX: return mms_pkg::PAT_ASX;
         mms_pkg::FOUND_M3U: return mms_pkg::PAT_M3U;
         mms_pkg::FOUND_SMOOTH: return mms_pkg::PAT_SMOOTH;
         default: return mms_pkg::PAT_WMS;
      endcase
   endfunction

   function automatic int pattern_length(input int idx);
      case (idx)
         mms_pkg::FOUND_ASX: return mms_pkg::PAT_ASX_LEN;
         mms_pkg::FOUND_M3U: return mms_pkg::PAT_M3U_LEN;
         mms_pkg::FOUND_SMOOTH: return mms_pkg::PAT_SMOOTH_LEN;
         default: return mms_pkg::PAT_WMS_LEN;
      endcase
   endfunction

   function automatic void sniff_clear();
      int i;
      for (i = 0; i < mms_pkg::WINDOW_DEPTH; i++) sniff_window[i] = 8'h00;
      sniff_pos = 8'd0;
      sniff_found = 4'd0;
      sniff_ended = 1'b0;
      sniff_mark = 1'b0;
   endfunction

   // True when the pattern ends with the current folded byte. The window holds the
   // previous bytes newest first, which lines up with the right-aligned pattern text.
   function automatic bit pattern_ends(input int idx, input logic [7:0] cur);
      logic [mms_pkg::PAT_W-1:0] text;
      int len;
      int i;
      bit hit;
      text = pattern_text(idx);
      len = pattern_length(idx);
      hit = (text[7:0] == cur);
      for (i = 0; i < len - 1; i++)
         if (sniff_window[i] != text[8*(i+1) +: 8]) hit = 1'b0;
      return hit;
   endfunction

   // A head pattern counts only if its first byte sits below early_limit, and never
   // once the position counter has saturated.
   function automatic bit starts_near_head(input int len);
      int pos;
      pos = int'(sniff_pos);
      if (sniff_pos == mms_pkg::POS_MAX || pos + 1 < len) return 1'b0;
      return (pos + 1 - len) < int'(early_limit_model);
   endfunction

   // Advances the predicted state by one accepted byte; on the final byte the class
   // is queued and the state starts over for the next content.
   function automatic void sniff_byte(input logic [7:0] raw, input logic last);
      logic [7:0] folded;
      mms_pkg::format_class_type cls;
      int i;
      folded = raw;
      if (sniff_pos == 8'd0) sniff_mark = (raw == mms_pkg::MARK_FIRST);
      else if (sniff_pos == 8'd1 && sniff_mark && raw != mms_pkg::MARK_SECOND)
         sniff_mark = 1'b0;
      if (raw == 8'h00) sniff_ended = 1'b1;
      if (!sniff_ended) begin
         if (raw >= "A" && raw <= "Z") folded = raw + 8'h20;
         if (pattern_ends(mms_pkg::FOUND_ASX, folded) &&
             starts_near_head(mms_pkg::PAT_ASX_LEN))
            sniff_found[mms_pkg::FOUND_ASX] = 1'b1;
         if (pattern_ends(mms_pkg::FOUND_M3U, folded) &&
             starts_near_head(mms_pkg::PAT_M3U_LEN))
            sniff_found[mms_pkg::FOUND_M3U] = 1'b1;
         if (pattern_ends(mms_pkg::FOUND_SMOOTH, folded))
            sniff_found[mms_pkg::FOUND_SMOOTH] = 1'b1;
         if (pattern_ends(mms_pkg::FOUND_WMS, folded))
            sniff_found[mms_pkg::FOUND_WMS] = 1'b1;
         for (i = mms_pkg::WINDOW_DEPTH - 1; i > 0; i--) sniff_window[i] = sniff_window[i-1];
         sniff_window[0] = folded;
      end
      if (!last) begin
         if (sniff_pos != mms_pkg::POS_MAX) sniff_pos = sniff_pos + 8'd1;
      end else begin
         if (sniff_mark && sniff_pos >= 8'd1) cls = mms_pkg::FMT_WIDE;
         else if (sniff_found[mms_pkg::FOUND_ASX]) cls = mms_pkg::FMT_ASX;
         else if (sniff_found[mms_pkg::FOUND_M3U]) cls = mms_pkg::FMT_M3U;
         else if (sniff_found[mms_pkg::FOUND_SMOOTH]) cls = mms_pkg::FMT_SMOOTH;
         else if (sniff_found[mms_pkg::FOUND_WMS]) cls = mms_pkg::FMT_WMS;
         else cls = mms_pkg::FMT_PROGRESSIVE;
         expected_classes.push_back(cls);
         sniff_clear();
      end
   endfunction

   // Filler is never zero. It leans on pattern letters and on the characters just
   // outside both letter ranges, so that folding and near misses get exercised.
   function automatic logic [7:0] filler_byte();
      string letters;
      letters = "<#=.asxetm3uohrngdifwMSXT";
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(1, 255));
         1: begin
            case ($urandom_range(0, 3))
               0: return 8'h40;
               1: return 8'h5B;
               2: return 8'h60;
               default: return 8'h7B;
            endcase
         end
         default: return letters[$urandom_range(0, letters.len() - 1)];
      endcase
   endfunction

   // Appends one pattern in mixed case; a spoiled copy loses or alters one character.
   function automatic void draft_pattern(input int idx, input bit may_spoil);
      logic [mms_pkg::PAT_W-1:0] text;
      logic [7:0] ch;
      int len;
      int k;
      int spoil;
      text = pattern_text(idx);
      len = pattern_length(idx);
      spoil = (may_spoil && $urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
      for (k = 0; k < len; k++) begin
         ch = text[8*(len-1-k) +: 8];
         if (ch >= "a" && ch <= "z" && $urandom_range(0, 2) == 0) ch = ch - 8'h20;
         if (k != spoil) draft.push_back(ch);
         else if ($urandom_range(0, 1) == 1) draft.push_back(ch ^ 8'h04);
      end
   endfunction

   function automatic void draft_text(input string s);
      int k;
      for (k = 0; k < s.len(); k++) draft.push_back(s[k]);
   endfunction

   // A head pattern after a long run of filler, to reach the saturated position.
   function automatic void draft_late(input int idx, input int prefix);
      int k;
      for (k = 0; k < prefix; k++) draft.push_back(filler_byte());
      draft_pattern(idx, 1'b0);
   endfunction

   function automatic void draft_random_content();
      int n;
      int k;
      int pick;
      int head_span;
      head_span = (early_limit_model > 8'd20) ? 23 : int'(early_limit_model) + 3;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         // Raw noise with frequent zero bytes.
         n = $urandom_range(1, 24);
         for (k = 0; k < n; k++)
            draft.push_back(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      end else if (pick == 1) begin
         // Byte-order mark variants: complete, alone, or broken in the second byte.
         draft.push_back(mms_pkg::MARK_FIRST);
         case ($urandom_range(0, 3))
            0: ;
            1: draft.push_back(mms_pkg::MARK_SECOND);
            2: begin
               draft.push_back(mms_pkg::MARK_SECOND);
               draft_pattern($urandom_range(0, 3), 1'b1);
            end
            default: begin
               draft.push_back(filler_byte());
               draft_pattern(mms_pkg::FOUND_ASX, 1'b1);
            end
         endcase
      end else begin
         // Well-formed text: filler, one or two patterns, sometimes cut off by a zero.
         n = $urandom_range(0, head_span);
         for (k = 0; k < n; k++) draft.push_back(filler_byte());
         n = $urandom_range(1, 2);
         repeat (n) begin
            if ($urandom_range(0, 9) == 0) draft.push_back(8'h00);
            draft_pattern($urandom_range(0, 3), 1'b1);
            repeat ($urandom_range(0, 3)) draft.push_back(filler_byte());
         end
      end
   endfunction

   // Hands the drafted content to the driver, marking its final byte.
   function automatic void queue_draft();
      stream_byte_type item;
      while (draft.size() != 0) begin
         item.value = draft.pop_front();
         item.last = (draft.size() == 0);
         pending_bytes.push_back(item);
      end
   endfunction

   function automatic void queue_random_contents(input int budget);
      int queued;
      queued = 0;
      while (queued < budget) begin
         draft_random_content();
         queued += draft.size();
         queue_draft();
      end
   endfunction

   // Idle means every byte is taken and every owed class has come back. The check
   // runs between clock edges, after the driver and monitor have settled.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || expected_classes.size() != 0)
         @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_limit(input logic [7:0] value);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      early_limit_model = value;
      csr_valid <= 1'b0;
   endtask

   // Byte driver: predicts each accepted transaction, then offers the next byte after
   // its drawn gap. Quiet stretches turn the gaps off for a while.
   always @(posedge clock) begin
      stream_byte_type next_byte;
      bit offer_free;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'h00;
         req_tlast <= 1'b0;
      end else begin
         offer_free = !req_tvalid;
         if (req_tvalid && req_tready) begin
            sniff_byte(req_tdata, req_tlast);
            offer_free = 1'b1;
         end
         if (offer_free) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               next_byte = pending_bytes.pop_front();
               req_tdata <= next_byte.value;
               req_tlast <= next_byte.last;
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 23) == 0) send_quiet = !send_quiet;
               send_gap = send_quiet ? 0 : $urandom_range(0, 16);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each class transaction against the oldest prediction and
   // draws its own stall before taking the next one.
   always @(posedge clock) begin
      mms_pkg::format_class_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_classes.size() == 0) begin
               $error("format_class: expected none, actual %0d", rsp_tdata[2:0]);
               errors++;
            end else begin
               want = expected_classes.pop_front();
               if (rsp_tdata[2:0] !== want) begin
                  $error("format_class: expected %0d, actual %0d", want, rsp_tdata[2:0]);
                  errors++;
               end
               if (rsp_tdata[7:3] !== 5'd0) begin
                  $error("tdata padding: expected 0, actual %0d", rsp_tdata[7:3]);
                  errors++;
               end
            end
            if ($urandom_range(0, 23) == 0) recv_quiet = !recv_quiet;
            recv_wait = recv_quiet ? 0 : $urandom_range(0, 16);
            // One long hold-off early on, and now and then a shorter one, so the byte
            // side backs up behind a full result register.
            if (results_seen == 8) recv_wait = 300;
            else if ($urandom_range(0, 63) == 0) recv_wait = $urandom_range(40, 120);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      sniff_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed contents at the reset value of early_limit: an upper-case head match,
      // a full byte-order mark, a lone FF, a zero byte that hides a pattern, a mixed-case
      // playlist header and a single plain byte.
      draft_text("<ASX");
      queue_draft();
      draft.push_back(mms_pkg::MARK_FIRST);
      draft.push_back(mms_pkg::MARK_SECOND);
      draft_text("x");
      queue_draft();
      draft.push_back(mms_pkg::MARK_FIRST);
      queue_draft();
      draft.push_back(8'h00);
      draft_text("<asx");
      queue_draft();
      draft_text("#ExtM3U");
      queue_draft();
      draft_text("Z");
      queue_draft();
      wait_idle();

      // No head pattern can count with a limit of zero.
      program_limit(8'd0);
      queue_random_contents(60);
      wait_idle();

      // Widest limit: a head pattern ending just before saturation counts, one ending
      // at the saturated position does not.
      program_limit(8'd255);
      draft_late(mms_pkg::FOUND_ASX, 251);
      queue_draft();
      draft_late(mms_pkg::FOUND_ASX, 252);
      queue_draft();
      draft_late(mms_pkg::FOUND_M3U, $urandom_range(244, 250));
      queue_draft();
      queue_random_contents(60);
      wait_idle();

      program_limit(8'($urandom_range(1, 254)));
      queue_random_contents(60);
      wait_idle();

      program_limit(8'd1);
      queue_random_contents(60);
      wait_idle();

      program_limit(mms_pkg::EARLY_LIMIT_RESET);
      queue_random_contents(60);
      wait_idle();

      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/mms_pkg.sv
sv/media_manifest_sniffer.sv
tb/sv/testbench.sv
